// ----- design/rbsor_pkg.sv -----
// rbsor_pkg: constants, opcodes and controller/datapath command types
// for the red-black SOR grid solver. No dependencies.
package rbsor_pkg;
	localparam int MAX_GRID_SIDE_DEF = 64;
	localparam int CELL_WIDTH_DEF    = 32;
	localparam int SUM_W             = 48;
	localparam int OMEGA_W           = 17;
	localparam int ITER_W            = 17;
	localparam int DIVL_W            = 31;
	localparam int CFG_W             = 48;
	localparam int CFG_IDX_W         = 3;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_CAP       = 2'd1;
	localparam logic [1:0] ST_DIVERGED  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OMEGA     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_CAP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_LIMIT = 3'd4;

	// Datapath read slot for a neighbor fetch.
	localparam logic [2:0] SLOT_OLD   = 3'd0;
	localparam logic [2:0] SLOT_UP    = 3'd1;
	localparam logic [2:0] SLOT_DOWN  = 3'd2;
	localparam logic [2:0] SLOT_LEFT  = 3'd3;
	localparam logic [2:0] SLOT_RIGHT = 3'd4;
	localparam logic [2:0] SLOT_WATCH = 3'd5;

	typedef struct packed {
		logic       clr_acc;   // start of an iteration
		logic       clr_flags; // start of a run
		logic       rd_valid;  // read data this cycle belongs to slot
		logic [2:0] rd_slot;
		logic       calc;      // compute step from captured operands
		logic       upd;       // write the new value, accumulate
	} dp_cmd_t;

	typedef struct packed {
		logic       sat;
		logic       wdiv;      // watched cell out of bound
		logic       below;     // acc below limit
	} dp_stat_t;
endpackage

// ----- design/rbsor_ram.sv -----
// rbsor_ram: generic single-port RAM with registered read.
// No dependencies.
module rbsor_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ----- design/rbsor_dp.sv -----
// rbsor_dp: operand registers, SOR update arithmetic, change accumulator
// and stop tests. Depends on rbsor_pkg.
module rbsor_dp #(
	parameter int CELL_WIDTH = rbsor_pkg::CELL_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rbsor_pkg::dp_cmd_t                  cmd,
	input  logic [CELL_WIDTH-1:0]               rdata,
	input  logic [rbsor_pkg::OMEGA_W-1:0]       omega,
	input  logic [rbsor_pkg::SUM_W-1:0]         sum_limit,
	input  logic [rbsor_pkg::DIVL_W-1:0]        div_limit,
	output logic [CELL_WIDTH-1:0]               new_val,
	output rbsor_pkg::dp_stat_t                 stat
);
	localparam int CB  = (CELL_WIDTH > 32) ? 32 : CELL_WIDTH;
	localparam int XW  = CB + 3;               // neighbor sum width
	localparam int PW  = XW + rbsor_pkg::OMEGA_W + 1;
	localparam int SW  = rbsor_pkg::SUM_W;

	logic signed [CB-1:0] old_q, up_q, dn_q, lf_q, rt_q;
	logic signed [XW-1:0] chg_q;
	logic signed [PW-1:0] prod_q;
	logic [SW-1:0]        acc_q;
	logic                 sat_q, wdiv_q;

	logic signed [CB-1:0] rd_s;
	logic signed [XW-1:0] nsum, chg;
	logic signed [PW-1:0] step, nv;
	logic [XW-1:0]        mag;
	logic [SW:0]          acc_n;
	logic signed [CB-1:0] nv_sat;
	logic                 nv_ovf;
	logic [CB-1:0]        wabs;

	assign rd_s = signed'(rdata[CB-1:0]);
	assign nsum = XW'(up_q) + XW'(dn_q) + XW'(lf_q) + XW'(rt_q);
	assign chg  = XW'(old_q) - (nsum >>> 2);
	assign step = (prod_q + PW'(32768)) >>> 16;
	assign nv   = PW'(old_q) - step;
	always_comb begin
		nv_ovf = 1'b0;
		nv_sat = nv[CB-1:0];
		if (nv > PW'(signed'({1'b0, {(CB-1){1'b1}}}))) begin
			nv_ovf = 1'b1; nv_sat = {1'b0, {(CB-1){1'b1}}};
		end else if (nv < -PW'(signed'({1'b0, {(CB-1){1'b1}}})) - PW'(1)) begin
			nv_ovf = 1'b1; nv_sat = {1'b1, {(CB-1){1'b0}}};
		end
	end
	assign mag   = chg_q[XW-1] ? XW'(-chg_q) : XW'(chg_q);
	assign acc_n = {1'b0, acc_q} + (SW+1)'(mag);
	assign wabs  = rd_s[CB-1] ? CB'(-rd_s) : CB'(rd_s);
	assign new_val = CELL_WIDTH'(nv_sat);

	always_ff @(posedge clk) begin
		if (cmd.rd_valid) begin
			case (cmd.rd_slot)
				rbsor_pkg::SLOT_OLD:   old_q <= rd_s;
				rbsor_pkg::SLOT_UP:    up_q  <= rd_s;
				rbsor_pkg::SLOT_DOWN:  dn_q  <= rd_s;
				rbsor_pkg::SLOT_LEFT:  lf_q  <= rd_s;
				rbsor_pkg::SLOT_RIGHT: rt_q  <= rd_s;
				default: ;
			endcase
		end
		if (cmd.calc) begin
			chg_q  <= chg;
			prod_q <= PW'(signed'({1'b0, omega})) * PW'(chg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; sat_q <= 1'b0; wdiv_q <= 1'b0;
		end else begin
			if (cmd.clr_flags) begin
				sat_q <= 1'b0; wdiv_q <= 1'b0;
			end
			if (cmd.clr_acc) begin
				acc_q <= '0; sat_q <= 1'b0;
			end else if (cmd.upd) begin
				if (nv_ovf) sat_q <= 1'b1;
				if (acc_n[SW]) begin
					acc_q <= {SW{1'b1}}; sat_q <= 1'b1;
				end else if (acc_n[SW-1:0] == {SW{1'b1}} && acc_n[SW-1:0] != '0) begin
					acc_q <= acc_n[SW-1:0];
				end else begin
					acc_q <= acc_n[SW-1:0];
				end
			end
			if (cmd.rd_valid && cmd.rd_slot == rbsor_pkg::SLOT_WATCH)
				wdiv_q <= 33'(wabs) > 33'(div_limit);
		end
	end

	assign stat.sat   = sat_q;
	assign stat.wdiv  = wdiv_q;
	assign stat.below = acc_q < sum_limit;
endmodule

// ----- design/rbsor_ctrl.sv -----
// rbsor_ctrl: command sequencer for write, read and run items, drives RAM
// address and datapath commands. Depends on rbsor_pkg.
module rbsor_ctrl #(
	parameter int MAX_GRID_SIDE = rbsor_pkg::MAX_GRID_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    opcode,
	input  logic [5:0]                    row,
	input  logic [5:0]                    col,
	input  logic [6:0]                    grid_size,
	input  logic [rbsor_pkg::ITER_W-1:0]  iter_cap,
	input  rbsor_pkg::dp_stat_t           stat,
	output logic                          busy,
	output logic [$clog2(MAX_GRID_SIDE*MAX_GRID_SIDE)-1:0] addr,
	output logic                          ram_we,
	output logic                          sel_in,   // write port data from cell_in
	output rbsor_pkg::dp_cmd_t            cmd,
	output logic                          rd_done,
	output logic                          rd_ok,
	output logic                          run_done,
	output logic [1:0]                    status,
	output logic [rbsor_pkg::ITER_W-1:0]  iters
);
	localparam int LG = $clog2(MAX_GRID_SIDE);
	localparam int AW = 2 * LG;
	localparam int GW = LG + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ROWST = 4'd1;  // position cell, then go to fetch
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_CALC  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_WR    = 4'd5;
	localparam logic [3:0] S_WATCH = 4'd6;
	localparam logic [3:0] S_WWAIT = 4'd7;
	localparam logic [3:0] S_TEST  = 4'd8;
	localparam logic [3:0] S_ITER  = 4'd9;

	logic [3:0]        state_q;
	logic [GW-1:0]     n_q, r_q, c_q;
	logic              col_q;            // 0 red, 1 black
	logic [2:0]        fcnt_q;
	logic              pend_q;           // read slot pending
	logic [2:0]        pslot_q;
	logic [rbsor_pkg::ITER_W-1:0] it_q, cap_q;
	logic              rd_q, rdok_q;
	logic [AW-1:0]     ra;
	logic [GW-1:0]     n_c;

	assign n_c = (grid_size < 7'd4) ? GW'(4) :
		(32'(grid_size) > MAX_GRID_SIDE) ? GW'(MAX_GRID_SIDE) : GW'(grid_size);

	function automatic logic [AW-1:0] at(input logic [GW-1:0] r, input logic [GW-1:0] c);
		at = {r[LG-1:0], c[LG-1:0]};
	endfunction

	function automatic logic [GW-1:0] first_c(input logic [GW-1:0] r, input logic k);
		first_c = ((r[0] ^ k) == 1'b1) ? GW'(1) : GW'(2);
	endfunction

	always_comb begin
		ra = at(r_q, c_q);
		case (fcnt_q)
			3'd0: ra = at(r_q, c_q);
			3'd1: ra = at(r_q - GW'(1), c_q);
			3'd2: ra = at(r_q + GW'(1), c_q);
			3'd3: ra = at(r_q, c_q - GW'(1));
			3'd4: ra = at(r_q, c_q + GW'(1));
			default: ra = at(r_q, c_q);
		endcase
		sel_in = 1'b0;
		ram_we = 1'b0;
		addr   = ra;
		if (state_q == S_IDLE) begin
			addr   = at(GW'(row), GW'(col));
			sel_in = 1'b1;
			ram_we = start && opcode == rbsor_pkg::OP_WRITE &&
				32'(row) < MAX_GRID_SIDE && 32'(col) < MAX_GRID_SIDE;
		end else if (state_q == S_WR) begin
			addr = at(r_q, c_q); ram_we = 1'b1;
		end else if (state_q == S_WATCH) begin
			addr = at(n_q - GW'(2), n_q - GW'(2));
		end
	end

	always_comb begin
		cmd = '0;
		cmd.rd_valid = pend_q;
		cmd.rd_slot  = pslot_q;
		cmd.calc     = state_q == S_MUL;
		cmd.upd      = state_q == S_WR;
		cmd.clr_acc  = state_q == S_ITER;
		cmd.clr_flags = state_q == S_IDLE && start && opcode == rbsor_pkg::OP_RUN;
	end

	assign busy = state_q != S_IDLE;
	assign rd_done = rd_q;
	assign rd_ok = rdok_q;
	assign iters = it_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; n_q <= '0; r_q <= '0; c_q <= '0; col_q <= 1'b0;
			fcnt_q <= '0; pend_q <= 1'b0; pslot_q <= '0; it_q <= '0; cap_q <= '0;
			rd_q <= 1'b0; rdok_q <= 1'b0; run_done <= 1'b0; status <= '0;
		end else begin
			rd_q <= 1'b0; run_done <= 1'b0; pend_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && opcode == rbsor_pkg::OP_READ) begin
						rd_q <= 1'b1;
						rdok_q <= 32'(row) < MAX_GRID_SIDE && 32'(col) < MAX_GRID_SIDE;
					end
					if (start && opcode == rbsor_pkg::OP_RUN) begin
						n_q <= n_c;
						cap_q <= (iter_cap == '0) ? rbsor_pkg::ITER_W'(1) : iter_cap;
						it_q <= '0;
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					col_q <= 1'b0; r_q <= GW'(1);
					c_q <= first_c(GW'(1), 1'b0);
					state_q <= S_ROWST;
				end
				S_ROWST: begin
					// advance to a valid cell in the current pass, switch to the black pass, or end the iteration
					if (r_q + GW'(1) >= n_q) begin
						if (!col_q) begin
							col_q <= 1'b1; r_q <= GW'(1);
							c_q <= first_c(GW'(1), 1'b1);
						end else begin
							it_q <= it_q + rbsor_pkg::ITER_W'(1);
							state_q <= S_WATCH;
						end
					end else if (c_q + GW'(1) >= n_q) begin
						r_q <= r_q + GW'(1);
						c_q <= first_c(r_q + GW'(1), col_q);
					end else begin
						fcnt_q <= 3'd0; state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					// one read per cycle, data lands in the next cycle
					pend_q <= 1'b1; pslot_q <= fcnt_q;
					if (fcnt_q == 3'd4) state_q <= S_CALC;
					else fcnt_q <= fcnt_q + 3'd1;
				end
				S_CALC: state_q <= S_MUL;   // right neighbor lands
				S_MUL:  state_q <= S_WR;    // captures change and product
				S_WR: begin
					c_q <= c_q + GW'(2);
					state_q <= S_ROWST;
				end
				S_WATCH: begin
					pend_q <= 1'b1; pslot_q <= rbsor_pkg::SLOT_WATCH;
					state_q <= S_WWAIT;
				end
				S_WWAIT: state_q <= S_TEST;
				S_TEST: begin
					if (stat.sat || stat.wdiv) begin
						status <= rbsor_pkg::ST_DIVERGED; run_done <= 1'b1; state_q <= S_IDLE;
					end else if (stat.below) begin
						status <= rbsor_pkg::ST_CONVERGED; run_done <= 1'b1; state_q <= S_IDLE;
					end else if (it_q >= cap_q) begin
						status <= rbsor_pkg::ST_CAP; run_done <= 1'b1; state_q <= S_IDLE;
					end else begin
						state_q <= S_ITER;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- design/red_black_sor_grid_solver.sv -----
// red_black_sor_grid_solver: top level, config registers, grid RAM,
// controller and datapath. Depends on rbsor_pkg, rbsor_ram, rbsor_ctrl, rbsor_dp.
//
// channel   | signals                                   | notes
// command   | start, busy, opcode, row, col, cell_in    | taken when start && !busy
// result    | done, cell_out, run_status, iterations_done, is_run_result | one-cycle strobe
// config    | cfg_we, cfg_index, cfg_data               | written each cycle cfg_we is high
//
// Write: never busy. Read: word strobed in the next cycle.
// Run: per interior cell five RAM reads through the single port, then
// multiply and write back; per iteration plus row/pass stepping and the stop tests.
// The single RAM port sets the rate. Reset clears control state and loads
// config defaults; grid contents are undefined until written. The receiver cannot stall.
module red_black_sor_grid_solver #(
	parameter int MAX_GRID_SIDE = rbsor_pkg::MAX_GRID_SIDE_DEF,
	parameter int CELL_WIDTH    = rbsor_pkg::CELL_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          opcode,
	input  logic [5:0]                          row,
	input  logic [5:0]                          col,
	input  logic signed [31:0]                  cell_in,
	output logic                                done,
	output logic signed [31:0]                  cell_out,
	output logic [1:0]                          run_status,
	output logic [16:0]                         iterations_done,
	output logic                                is_run_result,
	input  logic                                cfg_we,
	input  logic [rbsor_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbsor_pkg::CFG_W-1:0]         cfg_data
);
	localparam int DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = (CELL_WIDTH > 32) ? 32 : CELL_WIDTH;

	logic [6:0]                       grid_size_q;
	logic [rbsor_pkg::OMEGA_W-1:0]    omega_q;
	logic [rbsor_pkg::SUM_W-1:0]      sum_limit_q;
	logic [rbsor_pkg::ITER_W-1:0]     iter_cap_q;
	logic [rbsor_pkg::DIVL_W-1:0]     div_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= 7'd64;
			omega_q     <= 17'd124518;
			sum_limit_q <= 48'd40307;
			iter_cap_q  <= 17'd100000;
			div_limit_q <= 31'd104857600;
		end else if (cfg_we) begin
			case (cfg_index)
				rbsor_pkg::REG_GRID_SIZE: grid_size_q <= cfg_data[6:0];
				rbsor_pkg::REG_OMEGA:     omega_q     <= cfg_data[16:0];
				rbsor_pkg::REG_SUM_LIMIT: sum_limit_q <= cfg_data;
				rbsor_pkg::REG_ITER_CAP:  iter_cap_q  <= cfg_data[16:0];
				rbsor_pkg::REG_DIV_LIMIT: div_limit_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic [AW-1:0]          addr;
	logic                   ram_we, sel_in;
	logic [CELL_WIDTH-1:0]  wdata, rdata, new_val;
	logic signed [CB-1:0]   in_sat;
	rbsor_pkg::dp_cmd_t     cmd;
	rbsor_pkg::dp_stat_t    stat;
	logic                   rd_done, rd_ok, run_done;
	logic [1:0]             status;
	logic [rbsor_pkg::ITER_W-1:0] iters;

	// write items saturate to the cell range when cells are narrower than 32 bits
	always_comb begin
		if (33'(cell_in) > 33'(signed'({1'b0, {(CB-1){1'b1}}})) && CB < 32)
			in_sat = {1'b0, {(CB-1){1'b1}}};
		else if (33'(cell_in) < -33'(signed'({1'b0, {(CB-1){1'b1}}})) - 33'sd1 && CB < 32)
			in_sat = {1'b1, {(CB-1){1'b0}}};
		else
			in_sat = cell_in[CB-1:0];
	end
	assign wdata = sel_in ? CELL_WIDTH'(in_sat) : new_val;

	rbsor_ram #(.WIDTH(CELL_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	rbsor_ctrl #(.MAX_GRID_SIDE(MAX_GRID_SIDE)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode), .row(row),
		.col(col), .grid_size(grid_size_q), .iter_cap(iter_cap_q), .stat(stat),
		.busy(busy), .addr(addr), .ram_we(ram_we), .sel_in(sel_in), .cmd(cmd),
		.rd_done(rd_done), .rd_ok(rd_ok), .run_done(run_done), .status(status),
		.iters(iters)
	);

	rbsor_dp #(.CELL_WIDTH(CELL_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rdata(rdata), .omega(omega_q),
		.sum_limit(sum_limit_q), .div_limit(div_limit_q), .new_val(new_val),
		.stat(stat)
	);

	// result word: read data comes straight from the RAM output register
	logic signed [CB-1:0] rd_cell;
	assign rd_cell = rdata[CB-1:0];
	assign done            = rd_done | run_done;
	assign cell_out        = rd_done && rd_ok ? 32'(rd_cell) : 32'sd0;
	assign run_status      = run_done ? status : 2'd0;
	assign iterations_done = run_done ? iters : 17'd0;
	assign is_run_result   = run_done;
endmodule

// ----- test/rbsor_checker.sv -----
`timescale 1ns / 1ps
// rbsor_checker: watches the command, config and result ports of the SOR solver,
// predicts each result word and compares it. Depends on rbsor_pkg.
module rbsor_checker
	import rbsor_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [1:0]           opcode,
	input  logic [5:0]           row,
	input  logic [5:0]           col,
	input  logic signed [31:0]   cell_in,
	input  logic                 done,
	input  logic signed [31:0]   cell_out,
	input  logic [1:0]           run_status,
	input  logic [16:0]          iterations_done,
	input  logic                 is_run_result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending_words
);
	localparam int SIDE = MAX_GRID_SIDE_DEF;
	localparam longint CELL_HI = 64'sd2147483647;
	localparam longint CELL_LO = -64'sd2147483648;
	localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;

	typedef struct {
		logic [31:0] cell_val;
		logic [1:0]  status;
		logic [16:0] iters;
		logic        is_run;
	} result_word_t;

	result_word_t expected_words[$];

	longint          cells[SIDE*SIDE];
	longint unsigned change_sum;
	logic [6:0]      grid_side;
	longint          omega;
	longint unsigned sum_limit;
	int unsigned     iter_cap;
	longint          div_limit;

	initial fail_count = 0;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		fail_count = fail_count + 1;
	endtask

	// one colored pass over the interior, in place
	function automatic void sweep(int unsigned n, int unsigned color, inout bit sat);
		int unsigned r, c, at;
		longint old_v, nbr, change, step, nv;
		longint unsigned mag;
		for (r = 1; r + 1 < n; r++) begin
			c = ((r + color) & 1) ? 1 : 2;
			for (; c + 1 < n; c += 2) begin
				at = r * SIDE + c;
				old_v = cells[at];
				nbr = cells[at-SIDE] + cells[at+SIDE] + cells[at-1] + cells[at+1];
				change = old_v - (nbr >>> 2);
				step = (omega * change + 32768) >>> 16;
				nv = old_v - step;
				if (nv > CELL_HI) begin nv = CELL_HI; sat = 1; end
				if (nv < CELL_LO) begin nv = CELL_LO; sat = 1; end
				cells[at] = nv;
				mag = (change < 0) ? -change : change;
				if (change_sum + mag > SUM_MAX) begin
					change_sum = SUM_MAX;
					sat = 1;
				end else begin
					change_sum = change_sum + mag;
				end
			end
		end
	endfunction

	function automatic void solve_grid(output logic [1:0] st, output logic [16:0] its);
		int unsigned n, cap, cnt;
		bit sat;
		longint w;
		n = grid_side;
		if (n < 4) n = 4;
		if (n > SIDE) n = SIDE;
		cap = (iter_cap == 0) ? 1 : iter_cap;
		cnt = 0;
		while (1) begin
			sat = 0;
			change_sum = 0;
			sweep(n, 0, sat);
			sweep(n, 1, sat);
			cnt++;
			w = cells[(n-2)*SIDE + (n-2)];
			if (w < 0) w = -w;
			if (sat || w > div_limit) begin st = ST_DIVERGED; break; end
			if (change_sum < sum_limit) begin st = ST_CONVERGED; break; end
			if (cnt >= cap) begin st = ST_CAP; break; end
		end
		its = cnt[16:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_word_t w;
		if (!arst_n) begin
			grid_side = 7'd64;
			omega = 124518;
			sum_limit = 40307;
			iter_cap = 100000;
			div_limit = 104857600;
			change_sum = 0;
			expected_words.delete();
		end else begin
			// result first: a word strobed now belongs to an older command
			if (done) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected result word", cell_out, 0);
				end else begin
					w = expected_words.pop_front();
					if (cell_out !== w.cell_val)
						report_mismatch("cell_out", cell_out, $signed(w.cell_val));
					if (run_status !== w.status)
						report_mismatch("run_status", run_status, w.status);
					if (iterations_done !== w.iters)
						report_mismatch("iterations_done", iterations_done, w.iters);
					if (is_run_result !== w.is_run)
						report_mismatch("is_run_result", is_run_result, w.is_run);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_SIZE: grid_side = cfg_data[6:0];
					REG_OMEGA:     omega = cfg_data[OMEGA_W-1:0];
					REG_SUM_LIMIT: sum_limit = cfg_data[SUM_W-1:0];
					REG_ITER_CAP:  iter_cap = cfg_data[ITER_W-1:0];
					REG_DIV_LIMIT: div_limit = cfg_data[DIVL_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				w.cell_val = '0;
				w.status = ST_CONVERGED;
				w.iters = '0;
				w.is_run = 1'b0;
				case (opcode)
					OP_WRITE: cells[row*SIDE + col] = cell_in;
					OP_RUN: begin
						solve_grid(w.status, w.iters);
						w.is_run = 1'b1;
						expected_words.push_back(w);
					end
					OP_READ: begin
						w.cell_val = cells[row*SIDE + col][31:0];
						expected_words.push_back(w);
					end
					default: ;
				endcase
			end
		end
		pending_words <= expected_words.size();
	end
endmodule

// ----- test/red_black_sor_grid_solver_tb.sv -----
`timescale 1ns / 1ps
// red_black_sor_grid_solver_tb: stimulus and verdict for the SOR grid solver.
// Depends on rbsor_pkg, the solver RTL and rbsor_checker.
module red_black_sor_grid_solver_tb;
	import rbsor_pkg::*;

	// opcode the block must ignore
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam longint unsigned SUM_ALL = (64'd1 << SUM_W) - 1;
	localparam int DIV_ALL = 32'h7FFF_FFFF;
	// corner of the store that is loaded and read at random
	localparam int LOAD_SIDE = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [1:0]           opcode = OP_WRITE;
	logic [5:0]           row = '0;
	logic [5:0]           col = '0;
	logic signed [31:0]   cell_in = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_SIZE;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 busy, done, is_run_result;
	logic signed [31:0]   cell_out;
	logic [1:0]           run_status;
	logic [16:0]          iterations_done;
	int                   fail_count, pending_words;
	int                   side;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	red_black_sor_grid_solver dut (.*);
	rbsor_checker chk (.*);

	// Hard stop well beyond the slowest legal run.
	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Tasks are entered right after a rising edge and leave right after one.
	// busy only moves at rising edges, so sampling it at the falling edge
	// tells whether the next edge takes the word.
	task automatic send_word(logic [1:0] op, int r, int c, logic [31:0] v);
		start <= 1'b1;
		opcode <= op;
		row <= r[5:0];
		col <= c[5:0];
		cell_in <= v;
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
	endtask

	task automatic pause(int pct);
		int gap;
		gap = 0;
		while ($urandom_range(99) < pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until no word is owed and the block is free, plus slack for a write.
	task automatic wait_idle();
		start <= 1'b0;
		do @(negedge clk); while (pending_words != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(int n, int omega, longint unsigned lim, int cap, int div);
		logic [CFG_W-1:0]     vals[6];
		logic [CFG_IDX_W-1:0] idx[6];
		start <= 1'b0;
		idx[0] = REG_GRID_SIZE; vals[0] = CFG_W'(n);
		idx[1] = REG_OMEGA;     vals[1] = CFG_W'(omega);
		idx[2] = REG_SUM_LIMIT; vals[2] = CFG_W'(lim);
		idx[3] = REG_ITER_CAP;  vals[3] = CFG_W'(cap);
		idx[4] = REG_DIV_LIMIT; vals[4] = CFG_W'(div);
		// index past the register list, must be dropped
		idx[5] = CFG_IDX_W'(REG_DIV_LIMIT + 1 + $urandom_range(2));
		vals[5] = CFG_W'({$urandom, $urandom});
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// small Q11.20 values, about +-4, keep runs well behaved
	function automatic logic [31:0] small_cell();
		return int'($urandom_range(0, 8388608)) - 4194304;
	endfunction

	task automatic load_square(int n);
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				send_word(OP_WRITE, r, c, small_cell());
	endtask

	initial begin
		int pct_table[4];
		int idle_pct, sel, cap, div;
		longint unsigned lim;
		pct_table = '{0, 74, 0, 30};

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// every cell a run or a random read can reach is written first
		load_square(LOAD_SIDE);

		// ---- directed ----
		wait_idle();
		set_config(4, 65536, 0, 1, DIV_ALL);
		send_word(OP_RUN, 0, 0, 0);              // sum limit zero: stops on the cap
		send_word(OP_WRITE, 63, 63, small_cell());
		send_word(OP_WRITE, 0, 63, small_cell());
		send_word(OP_WRITE, 63, 0, small_cell());
		send_word(OP_READ, 0, 0, 0);
		send_word(OP_READ, 63, 63, 0);
		send_word(OP_READ, 0, 63, 0);
		send_word(OP_READ, 63, 0, 0);
		send_word(OP_WRITE, 63, 63, 32'h7FFF_FFFF);
		send_word(OP_READ, 63, 63, 0);
		send_word(OP_WRITE, 63, 63, 32'h8000_0000);
		send_word(OP_READ, 63, 63, 0);
		send_word(OP_NONE, 5, 5, $urandom);      // ignored, no word
		send_word(OP_READ, 5, 5, 0);
		wait_idle();
		set_config(4, 1, SUM_ALL, 0, DIV_ALL);   // cap zero acts as one
		send_word(OP_RUN, 0, 0, 0);
		wait_idle();
		set_config(0, 131071, SUM_ALL, 3, 0);    // side below range, zero divergence bound
		send_word(OP_RUN, 0, 0, 0);
		wait_idle();
		// saturation: border at the top of the range, interior at the bottom
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				send_word(OP_WRITE, r, c,
					(r == 0 || c == 0 || r == 3 || c == 3) ? 32'h7FFF_FFFF : 32'h8000_0000);
		set_config(4, 131071, 0, 4, DIV_ALL);
		send_word(OP_RUN, 0, 0, 0);
		send_word(OP_READ, 1, 1, 0);
		load_square(LOAD_SIDE);

		// ---- random phases ----
		for (int ph = 0; ph < 11; ph++) begin
			idle_pct = pct_table[ph % 4];
			wait_idle();
			side = $urandom_range(4, LOAD_SIDE);
			case ($urandom_range(3))
				0: lim = 0;
				1: lim = $urandom_range(0, 1 << 22);
				2: lim = {$urandom, $urandom} & SUM_ALL;
				default: lim = SUM_ALL;
			endcase
			cap = $urandom_range(0, 8);
			if (lim == SUM_ALL && $urandom_range(1)) cap = 100000;
			case ($urandom_range(7))
				0: div = 0;
				1: div = 100 << 20;
				default: div = $urandom & DIV_ALL;
			endcase
			case (ph % 3)
				0: set_config(side, $urandom_range(1, 131071), lim, cap, div);
				1: set_config(side, 131071, lim, cap, div);
				default: set_config(side, $urandom_range(1, 2), lim, cap, div);
			endcase
			for (int k = 0; k < 100; k++) begin
				if (ph == 5 && k == 50) wait_idle();
				pause(idle_pct);
				sel = $urandom_range(99);
				if (sel < 28)
					send_word(OP_WRITE, $urandom_range(side - 1), $urandom_range(side - 1),
						small_cell());
				else if (sel < 40)
					send_word(OP_WRITE, $urandom_range(63), $urandom_range(63), $urandom);
				else if (sel < 88)
					send_word(OP_READ, $urandom_range(LOAD_SIDE - 1),
						$urandom_range(LOAD_SIDE - 1), $urandom);
				else if (sel < 96)
					send_word(OP_RUN, $urandom_range(63), $urandom_range(63), $urandom);
				else
					send_word(OP_NONE, $urandom_range(63), $urandom_range(63), $urandom);
			end
		end

		// drain, then a little slack for a stray strobe
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- red_black_sor_grid_solver.f -----
design/rbsor_pkg.sv
design/rbsor_ram.sv
design/rbsor_dp.sv
design/rbsor_ctrl.sv
design/red_black_sor_grid_solver.sv
test/rbsor_checker.sv
test/red_black_sor_grid_solver_tb.sv
